### sv/arc_pkg.sv
// Package with the word types, codes and constants of the alarm ring controller.
package arc_pkg;

    localparam int unsigned ALARMS = 4;
    localparam int unsigned IDX_W  = (ALARMS > 1) ? $clog2(ALARMS) : 1;

    localparam logic [31:0] RING_LIMIT_RST  = 32'd300000;
    localparam logic [15:0] BLINK_PER_RST   = 16'd400;
    localparam logic [15:0] SNOOZE_SEC_RST  = 16'd540;
    localparam logic [31:0] CLOCK_FLOOR_RST = 32'd1700000000;
    localparam logic [31:0] CATCH_WINDOW_S  = 32'd90;
    localparam logic [2:0]  SIG_DEFAULT     = 3'd3;
    localparam logic [2:0]  SIG_ALL         = 3'd7;
    localparam logic [31:0] DIV60_RECIP     = 32'h8888_8889;
    localparam int unsigned DIV60_SHIFT     = 37;
    localparam int unsigned MIN_W           = 27;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SNOOZE  = 2'd1,
        KIND_DISMISS = 2'd2,
        KIND_TEST    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ALARM     = 3'd1,
        EV_SNZ_RING  = 3'd2,
        EV_AUTO_DISM = 3'd3,
        EV_SNOOZED   = 3'd4,
        EV_DISMISSED = 3'd5,
        EV_TEST      = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        REG_ALARM_0     = 3'd0,
        REG_ALARM_1     = 3'd1,
        REG_ALARM_2     = 3'd2,
        REG_ALARM_3     = 3'd3,
        REG_RING_LIMIT  = 3'd4,
        REG_BLINK_PER   = 3'd5,
        REG_SNOOZE_SEC  = 3'd6,
        REG_CLOCK_FLOOR = 3'd7
    } t_reg_idx;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_seconds;
        logic [31:0] now_ms;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
    } t_in_word;

    typedef struct packed {
        logic       ringing;
        logic       tone_on;
        logic       blink_on;
        logic       vibra_on;
        logic [2:0] event_res;
        logic [1:0] alarm_index;
        logic       alarm_spent;
    } t_out_word;

    typedef struct packed {
        logic [7:0] day_mask;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [2:0] rsvd;
        logic       once;
        logic [2:0] signal;
        logic       enable;
    } t_alarm_word;

    typedef struct packed {
        logic [31:0] res;
        logic        ge;
        logic        zero;
    } t_alu_res;

    typedef struct packed {
        logic       hit;
        logic       once;
        logic [2:0] signal;
    } t_match;

endpackage

### sv/arc_alu.sv
// Shared 32-bit adder and subtractor with compare flags.
module arc_alu import arc_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_alu_res    o_res
);

    logic [32:0] w_sum;

    always_comb begin
        if (i_op == ALU_ADD) begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end else begin
            w_sum = {1'b0, i_a} - {1'b0, i_b};
        end
        o_res.res  = w_sum[31:0];
        o_res.ge   = ~w_sum[32];
        o_res.zero = (w_sum[31:0] == 32'd0);
    end

endmodule

### sv/arc_match.sv
// Match of one alarm word against the local hour, minute and weekday.
module arc_match import arc_pkg::*; (
    input  t_alarm_word i_word,
    input  logic        i_spent,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [2:0]  i_weekday,
    output t_match      o_match
);

    logic w_time_ok;
    logic w_day_ok;

    always_comb begin
        w_time_ok = (i_word.hour == {3'd0, i_hour}) && (i_word.minute == {2'd0, i_minute});
        w_day_ok  = i_word.once || (i_word.day_mask == 8'd0) || i_word.day_mask[i_weekday];
        o_match.hit    = i_word.enable && !i_spent && w_time_ok && w_day_ok;
        o_match.once   = i_word.once;
        o_match.signal = i_word.signal;
    end

endmodule

### sv/alarm_ring_controller_top.sv
// Top level of the alarm ring controller with its sequencer and state.
//
// One word is taken at a time and o_in_stall stays high until its result word
// has been loaded into the output register. Snooze, dismiss and test-fire
// words go from dispatch to the result hand-off, a snooze while ringing by way
// of the snooze add. A tick while ringing runs the blink and ring-limit
// subtract and compare steps. A tick while not ringing checks the clock floor,
// the snooze restart window and the minute multiply and compare, then scans
// the alarms, one alarm per cycle; it ends early when the clock is unset, a
// snooze restarts or the current minute was already served. The single shared
// adder and subtractor performs every time comparison in turn, and the result
// hand-off waits while the output side is stalled.
module alarm_ring_controller_top import arc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SNZ_ADD,
        S_BLK_SUB,
        S_BLK_CMP,
        S_LIM_SUB,
        S_LIM_CMP,
        S_FLOOR,
        S_SNZ_SUB,
        S_SNZ_WIN,
        S_MIN_MUL,
        S_MIN_CMP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    t_in_word          r_in;
    t_alarm_word       r_alarm [ALARMS];
    logic [31:0]       r_ring_limit;
    logic [15:0]       r_blink_per;
    logic [15:0]       r_snooze_sec;
    logic [31:0]       r_clock_floor;
    logic              r_ring_active;
    logic [31:0]       r_ring_start;
    logic [MIN_W-1:0]  r_last_min;
    logic [31:0]       r_snooze_tgt;
    logic [2:0]        r_ring_sig;
    logic              r_blink_phase;
    logic [31:0]       r_blink_tgl;
    logic [ALARMS-1:0] r_spent;
    logic [31:0]       r_diff;
    logic              r_late;
    logic [MIN_W-1:0]  r_cur_min;
    logic [IDX_W-1:0]  r_idx;
    t_event            r_event;
    logic [1:0]        r_ev_idx;
    logic              r_ev_spent;
    logic              r_out_valid;
    t_out_word         r_out;

    t_alu_op           w_op;
    logic [31:0]       w_a;
    logic [31:0]       w_b;
    t_alu_res          w_alu;
    t_match            w_match;
    logic [63:0]       w_prod;

    arc_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_alu)
    );

    arc_match u_match (
        .i_word    (r_alarm[r_idx]),
        .i_spent   (r_spent[r_idx]),
        .i_hour    (r_in.hour),
        .i_minute  (r_in.minute),
        .i_weekday (r_in.weekday),
        .o_match   (w_match)
    );

    assign w_prod = r_in.now_seconds * DIV60_RECIP;

    always_comb begin
        w_op = ALU_SUB;
        w_a  = r_in.now_seconds;
        w_b  = r_clock_floor;
        case (r_state)
            S_SNZ_ADD: begin
                w_op = ALU_ADD;
                w_b  = {16'd0, r_snooze_sec};
            end
            S_BLK_SUB: begin
                w_a = r_in.now_ms;
                w_b = r_blink_tgl;
            end
            S_BLK_CMP: begin
                w_a = r_diff;
                w_b = {16'd0, r_blink_per};
            end
            S_LIM_SUB: begin
                w_a = r_in.now_ms;
                w_b = r_ring_start;
            end
            S_LIM_CMP: begin
                w_a = r_diff;
                w_b = r_ring_limit;
            end
            S_SNZ_SUB: begin
                w_b = r_snooze_tgt;
            end
            S_SNZ_WIN: begin
                w_a = r_diff;
                w_b = CATCH_WINDOW_S;
            end
            S_MIN_CMP: begin
                w_a = {{(32-MIN_W){1'b0}}, r_cur_min};
                w_b = {{(32-MIN_W){1'b0}}, r_last_min};
            end
            default: begin
                w_op = ALU_SUB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            for (int i = 0; i < ALARMS; i++) begin
                r_alarm[i] <= '0;
            end
            r_ring_limit  <= RING_LIMIT_RST;
            r_blink_per   <= BLINK_PER_RST;
            r_snooze_sec  <= SNOOZE_SEC_RST;
            r_clock_floor <= CLOCK_FLOOR_RST;
            r_ring_active <= 1'b0;
            r_ring_start  <= '0;
            r_last_min    <= '0;
            r_snooze_tgt  <= '0;
            r_ring_sig    <= SIG_DEFAULT;
            r_blink_phase <= 1'b0;
            r_blink_tgl   <= '0;
            r_spent       <= '0;
            r_out_valid   <= 1'b0;
            r_event       <= EV_NONE;
            r_ev_idx      <= '0;
            r_ev_spent    <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ALARM_0, REG_ALARM_1, REG_ALARM_2, REG_ALARM_3: begin
                        if (32'(i_cfg_index) < ALARMS) begin
                            r_alarm[i_cfg_index[IDX_W-1:0]] <= t_alarm_word'(i_cfg_data);
                            r_spent[i_cfg_index[IDX_W-1:0]] <= 1'b0;
                        end
                    end
                    REG_RING_LIMIT:  r_ring_limit  <= i_cfg_data;
                    REG_BLINK_PER:   r_blink_per   <= i_cfg_data[15:0];
                    REG_SNOOZE_SEC:  r_snooze_sec  <= i_cfg_data[15:0];
                    REG_CLOCK_FLOOR: r_clock_floor <= i_cfg_data;
                    default: begin
                        r_ring_limit <= r_ring_limit;
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in       <= i_in_word;
                        r_event    <= EV_NONE;
                        r_ev_idx   <= '0;
                        r_ev_spent <= 1'b0;
                        r_state    <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (t_kind'(r_in.kind))
                        KIND_SNOOZE: begin
                            r_state <= r_ring_active ? S_SNZ_ADD : S_DONE;
                        end
                        KIND_DISMISS: begin
                            r_ring_active <= 1'b0;
                            r_snooze_tgt  <= '0;
                            r_event       <= EV_DISMISSED;
                            r_state       <= S_DONE;
                        end
                        KIND_TEST: begin
                            r_ring_sig    <= SIG_ALL;
                            r_ring_active <= 1'b1;
                            r_ring_start  <= r_in.now_ms;
                            r_blink_phase <= 1'b1;
                            r_blink_tgl   <= r_in.now_ms;
                            r_event       <= EV_TEST;
                            r_state       <= S_DONE;
                        end
                        default: begin
                            r_state <= r_ring_active ? S_BLK_SUB : S_FLOOR;
                        end
                    endcase
                end
                S_SNZ_ADD: begin
                    r_ring_active <= 1'b0;
                    r_snooze_tgt  <= w_alu.res;
                    r_event       <= EV_SNOOZED;
                    r_state       <= S_DONE;
                end
                S_BLK_SUB: begin
                    r_diff  <= w_alu.res;
                    r_state <= S_BLK_CMP;
                end
                S_BLK_CMP: begin
                    if (w_alu.ge) begin
                        r_blink_tgl   <= r_in.now_ms;
                        r_blink_phase <= ~r_blink_phase;
                    end
                    r_state <= S_LIM_SUB;
                end
                S_LIM_SUB: begin
                    r_diff  <= w_alu.res;
                    r_state <= S_LIM_CMP;
                end
                S_LIM_CMP: begin
                    if (w_alu.ge) begin
                        r_ring_active <= 1'b0;
                        r_snooze_tgt  <= '0;
                        r_event       <= EV_AUTO_DISM;
                    end
                    r_state <= S_DONE;
                end
                S_FLOOR: begin
                    r_state <= w_alu.ge ? S_SNZ_SUB : S_DONE;
                end
                S_SNZ_SUB: begin
                    r_diff  <= w_alu.res;
                    r_late  <= w_alu.ge;
                    r_state <= S_SNZ_WIN;
                end
                S_SNZ_WIN: begin
                    if ((r_snooze_tgt != 32'd0) && r_late && !w_alu.ge) begin
                        r_snooze_tgt  <= '0;
                        r_ring_active <= 1'b1;
                        r_ring_start  <= r_in.now_ms;
                        r_blink_phase <= 1'b1;
                        r_blink_tgl   <= r_in.now_ms;
                        r_event       <= EV_SNZ_RING;
                        r_state       <= S_DONE;
                    end else begin
                        if ((r_snooze_tgt != 32'd0) && r_late) begin
                            r_snooze_tgt <= '0;
                        end
                        r_state <= S_MIN_MUL;
                    end
                end
                S_MIN_MUL: begin
                    r_cur_min <= w_prod[DIV60_SHIFT +: MIN_W];
                    r_state   <= S_MIN_CMP;
                end
                S_MIN_CMP: begin
                    r_idx   <= '0;
                    r_state <= w_alu.zero ? S_DONE : S_SCAN;
                end
                S_SCAN: begin
                    if (w_match.hit) begin
                        r_last_min    <= r_cur_min;
                        r_ring_sig    <= (w_match.signal == 3'd0) ? SIG_DEFAULT : w_match.signal;
                        r_ring_active <= 1'b1;
                        r_ring_start  <= r_in.now_ms;
                        r_blink_phase <= 1'b1;
                        r_blink_tgl   <= r_in.now_ms;
                        r_event       <= EV_ALARM;
                        r_ev_idx      <= 2'(r_idx);
                        if (w_match.once) begin
                            r_spent[r_idx] <= 1'b1;
                            r_ev_spent     <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (r_idx == IDX_W'(ALARMS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.ringing     <= r_ring_active;
                        r_out.tone_on     <= r_ring_active & r_ring_sig[0];
                        r_out.blink_on    <= r_ring_active & r_ring_sig[1] & r_blink_phase;
                        r_out.vibra_on    <= r_ring_active & r_ring_sig[2] & r_blink_phase;
                        r_out.event_res   <= r_event;
                        r_out.alarm_index <= r_ev_idx;
                        r_out.alarm_spent <= r_ev_spent;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### sv/arc_checker.sv
// Port checker for the alarm ring controller and its bind to the top level.
module arc_checker import arc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_word    i_in_word,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_word   o_out_word,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled result word changed.");

    a_drive_needs_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.ringing |->
            !o_out_word.tone_on && !o_out_word.blink_on && !o_out_word.vibra_on)
        else $error("Signal drive without ringing.");

    a_event_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.event_res == EV_ALARM || o_out_word.event_res == EV_SNZ_RING
            || o_out_word.event_res == EV_TEST) |-> o_out_word.ringing)
        else $error("Ring event without ringing.");

    a_event_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.event_res == EV_AUTO_DISM
            || o_out_word.event_res == EV_SNOOZED || o_out_word.event_res == EV_DISMISSED)
            |-> !o_out_word.ringing)
        else $error("Stop event while still ringing.");

    a_spent_on_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.alarm_spent || o_out_word.alarm_index != 2'd0)
            |-> o_out_word.event_res == EV_ALARM)
        else $error("Alarm index or spent flag outside an alarm ring event.");

endmodule

bind alarm_ring_controller_top arc_checker u_arc_checker (.*);

### dv/alarm_ring_controller_top_test.sv
// Self-checking testbench for the alarm ring controller with random handshake pauses.
module alarm_ring_controller_top_test import arc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ALARM_WORDS     = 4;
    localparam int unsigned RANDOM_SETTINGS = 8;
    localparam int unsigned WORDS_PER_SET   = 56;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam logic [31:0] BASE_S          = 32'd1800000000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Copy of the controller's registers and state, kept by the predictor.
    t_alarm_word alarm_reg [ALARM_WORDS] = '{default: '0};
    logic [31:0] ring_limit   = RING_LIMIT_RST;
    logic [15:0] blink_period = BLINK_PER_RST;
    logic [15:0] snooze_sec   = SNOOZE_SEC_RST;
    logic [31:0] clock_floor  = CLOCK_FLOOR_RST;
    logic        ring_on      = 1'b0;
    logic [31:0] ring_start   = '0;
    logic [26:0] last_minute  = '0;
    logic [31:0] snooze_due   = '0;
    logic [2:0]  ring_sig     = SIG_DEFAULT;
    logic        blink_ph     = 1'b0;
    logic [31:0] blink_mark   = '0;
    logic [3:0]  spent_bits   = '0;

    t_in_word    queued_commands [$];
    t_out_word   predicted_outputs [$];

    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned in_gap_max = 17;
    int unsigned out_gap_max = 17;
    int unsigned in_gap_left = 0;
    int unsigned out_hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned setting_count = 0;
    int unsigned event_count [8] = '{default: 0};

    logic [31:0] clock_s = '0;
    logic [31:0] clock_ms = '0;
    logic [31:0] snooze_at_gen = '0;

    alarm_ring_controller_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void start_ring(logic [2:0] sig, logic [31:0] ms);
        ring_sig   = (sig == 3'd0) ? SIG_DEFAULT : sig;
        ring_on    = 1'b1;
        ring_start = ms;
        blink_ph   = 1'b1;
        blink_mark = ms;
    endfunction

    function automatic t_out_word alarm_response(t_in_word w);
        t_out_word   r;
        t_alarm_word a;
        logic [31:0] cur_min;
        logic [2:0]  ev;
        logic [1:0]  idx;
        logic        spent;
        logic        done;
        ev = EV_NONE;
        idx = '0;
        spent = 1'b0;
        done = 1'b0;
        case (t_kind'(w.kind))
            KIND_SNOOZE: if (ring_on) begin
                ring_on = 1'b0;
                snooze_due = w.now_seconds + 32'(snooze_sec);
                ev = EV_SNOOZED;
            end
            KIND_DISMISS: begin
                ring_on = 1'b0;
                snooze_due = '0;
                ev = EV_DISMISSED;
            end
            KIND_TEST: begin
                start_ring(SIG_ALL, w.now_ms);
                ev = EV_TEST;
            end
            KIND_TICK: if (ring_on) begin
                if (w.now_ms - blink_mark >= 32'(blink_period)) begin
                    blink_mark = w.now_ms;
                    blink_ph = ~blink_ph;
                end
                if (w.now_ms - ring_start >= ring_limit) begin
                    ring_on = 1'b0;
                    snooze_due = '0;
                    ev = EV_AUTO_DISM;
                end
            end else if (w.now_seconds >= clock_floor) begin
                if (snooze_due != '0 && w.now_seconds >= snooze_due &&
                    w.now_seconds - snooze_due < CATCH_WINDOW_S) begin
                    snooze_due = '0;
                    start_ring(ring_sig, w.now_ms);
                    ev = EV_SNZ_RING;
                end else begin
                    if (snooze_due != '0 && w.now_seconds >= snooze_due) snooze_due = '0;
                    cur_min = w.now_seconds / 32'd60;
                    if (cur_min != 32'(last_minute)) begin
                        for (int i = 0; i < ALARMS; i++) begin
                            a = alarm_reg[i];
                            if (!done && a.enable && !spent_bits[i] &&
                                a.hour == 8'(w.hour) && a.minute == 8'(w.minute) &&
                                (a.once || a.day_mask == '0 || a.day_mask[w.weekday])) begin
                                done = 1'b1;
                                last_minute = cur_min[26:0];
                                start_ring(a.signal, w.now_ms);
                                ev = EV_ALARM;
                                idx = 2'(i);
                                if (a.once) begin
                                    spent_bits[i] = 1'b1;
                                    spent = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.ringing     = ring_on;
        r.tone_on     = ring_on & ring_sig[0];
        r.blink_on    = ring_on & ring_sig[1] & blink_ph;
        r.vibra_on    = ring_on & ring_sig[2] & blink_ph;
        r.event_res   = ev;
        r.alarm_index = idx;
        r.alarm_spent = spent;
        return r;
    endfunction

    function automatic void add_word(t_kind k, logic [31:0] s, logic [31:0] ms,
                                     logic [4:0] h, logic [5:0] mi, logic [2:0] d);
        queued_commands.push_back('{k, s, ms, h, mi, d});
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RING_LIMIT:  ring_limit = value;
            REG_BLINK_PER:   blink_period = value[15:0];
            REG_SNOOZE_SEC:  snooze_sec = value[15:0];
            REG_CLOCK_FLOOR: clock_floor = value;
            default: begin
                alarm_reg[2'(idx)] = value;
                spent_bits[2'(idx)] = 1'b0;
            end
        endcase
    endtask

    // Returns once every queued word has been answered and the block has settled.
    task automatic drain();
        while (queued_commands.size() != 0 || in_valid || predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (in_gap_left != 0) begin
                in_valid <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end else if (queued_commands.size() != 0) begin
                in_word <= queued_commands.pop_front();
                in_valid <= 1'b1;
                in_gap_left <= $urandom_range(0, in_gap_max);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : out_side
        int unsigned draw;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold_left <= 0;
        end else if (out_taken) begin
            draw = $urandom_range(0, out_gap_max);
            out_hold_left <= draw;
            out_stall <= (draw != 0);
        end else if (out_hold_left != 0) begin
            out_hold_left <= out_hold_left - 1;
            out_stall <= (out_hold_left > 1);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (!rst_n) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (in_valid && !in_stall) begin
                predicted_outputs.push_back(alarm_response(in_word));
                words_sent++;
            end
            if (out_valid && !out_stall) begin
                if (predicted_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result word %p arrived with nothing expected", out_word);
                end else begin
                    want = predicted_outputs.pop_front();
                    results_checked++;
                    event_count[want.event_res]++;
                    if (out_word.ringing !== want.ringing ||
                        out_word.tone_on !== want.tone_on ||
                        out_word.blink_on !== want.blink_on ||
                        out_word.vibra_on !== want.vibra_on ||
                        out_word.event_res !== want.event_res ||
                        out_word.alarm_index !== want.alarm_index ||
                        out_word.alarm_spent !== want.alarm_spent) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Result %0d expected ring %b tone %b blink %b vibra %b event %0d alarm %0d spent %b",
                                     results_checked, want.ringing, want.tone_on, want.blink_on,
                                     want.vibra_on, want.event_res, want.alarm_index,
                                     want.alarm_spent);
                            $display("Result %0d got      ring %b tone %b blink %b vibra %b event %0d alarm %0d spent %b",
                                     results_checked, out_word.ringing, out_word.tone_on,
                                     out_word.blink_on, out_word.vibra_on, out_word.event_res,
                                     out_word.alarm_index, out_word.alarm_spent);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     predicted_outputs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        t_alarm_word aw;
        int unsigned pick;
        logic [31:0] lim;
        logic [31:0] per;
        logic [31:0] snz;
        logic [31:0] flr;
        logic [4:0]  h;
        logic [5:0]  mi;
        t_kind       k;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_ALARM_0, t_alarm_word'{8'h01, 8'd30, 8'd7, 3'd0, 1'b0, 3'd0, 1'b1});
        write_reg(REG_ALARM_1, t_alarm_word'{8'h40, 8'd31, 8'd7, 3'd0, 1'b1, 3'd4, 1'b1});
        write_reg(REG_ALARM_2, t_alarm_word'{8'h80, 8'd30, 8'd7, 3'd0, 1'b0, 3'd7, 1'b1});
        write_reg(REG_ALARM_3, t_alarm_word'{8'h00, 8'd0, 8'd8, 3'd0, 1'b0, 3'd2, 1'b1});
        setting_count++;
        @(posedge clk);
        add_word(KIND_TICK, 32'd0, 32'd0, 5'd7, 6'd30, 3'd0);
        add_word(KIND_TICK, BASE_S, 32'd1000, 5'd7, 6'd30, 3'd0);
        add_word(KIND_TICK, BASE_S + 1, 32'd1399, 5'd7, 6'd30, 3'd0);
        add_word(KIND_TICK, BASE_S + 1, 32'd1400, 5'd7, 6'd30, 3'd0);
        add_word(KIND_SNOOZE, BASE_S + 10, 32'd1500, 5'd7, 6'd30, 3'd0);
        add_word(KIND_SNOOZE, BASE_S + 11, 32'd1600, 5'd7, 6'd30, 3'd0);
        add_word(KIND_TICK, BASE_S + 549, 32'd2000, 5'd7, 6'd39, 3'd0);
        add_word(KIND_TICK, BASE_S + 550, 32'd3000, 5'd7, 6'd39, 3'd0);
        add_word(KIND_DISMISS, BASE_S + 551, 32'd3100, 5'd7, 6'd39, 3'd0);
        add_word(KIND_TICK, BASE_S + 60, 32'd5000, 5'd7, 6'd30, 3'd7);
        add_word(KIND_TICK, BASE_S + 61, 32'd305000, 5'd7, 6'd30, 3'd7);
        add_word(KIND_TICK, BASE_S + 120, 32'd306000, 5'd7, 6'd31, 3'd3);
        add_word(KIND_DISMISS, BASE_S + 121, 32'd306100, 5'd7, 6'd31, 3'd3);
        add_word(KIND_TICK, BASE_S + 240, 32'd307000, 5'd7, 6'd31, 3'd6);
        add_word(KIND_TEST, BASE_S + 241, 32'd308000, 5'd7, 6'd31, 3'd6);
        add_word(KIND_TEST, BASE_S + 242, 32'd308100, 5'd7, 6'd31, 3'd6);
        add_word(KIND_SNOOZE, BASE_S + 300, 32'd308200, 5'd7, 6'd35, 3'd6);
        add_word(KIND_TICK, BASE_S + 930, 32'd309000, 5'd8, 6'd0, 3'd5);
        add_word(KIND_DISMISS, BASE_S + 931, 32'd309100, 5'd8, 6'd0, 3'd5);
        add_word(KIND_TICK, BASE_S + 935, 32'd310000, 5'd8, 6'd0, 3'd5);
        add_word(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 6'd63, 3'd7);
        drain();

        // A maximal snooze that wraps to zero leaves nothing pending.
        write_reg(REG_SNOOZE_SEC, {16'($urandom), 16'hFFFF});
        write_reg(REG_ALARM_1, alarm_reg[1]);
        setting_count++;
        @(posedge clk);
        add_word(KIND_TEST, 32'd0, 32'd0, 5'd0, 6'd0, 3'd0);
        add_word(KIND_SNOOZE, 32'hFFFF_0001, 32'd10, 5'd0, 6'd0, 3'd0);
        add_word(KIND_TICK, 32'hFFFF_FFF0, 32'd20, 5'd7, 6'd31, 3'd0);
        drain();

        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            case (ph % 6)
                0: begin
                    lim = RING_LIMIT_RST;
                    per = BLINK_PER_RST;
                    snz = SNOOZE_SEC_RST;
                    flr = CLOCK_FLOOR_RST;
                end
                1: begin
                    lim = '0;
                    per = '0;
                    snz = '0;
                    flr = '0;
                end
                2: begin
                    lim = 32'd1;
                    per = 32'd1;
                    snz = 32'd1;
                    flr = '0;
                end
                3: begin
                    lim = 32'hFFFF_FFFF;
                    per = 32'h0000_FFFF;
                    snz = 32'h0000_FFFF;
                    flr = 32'hFFFF_FFFF;
                end
                default: begin
                    lim = $urandom_range(50, 20000);
                    per = $urandom_range(1, 2000);
                    snz = $urandom_range(1, 900);
                    flr = $urandom;
                end
            endcase
            in_gap_max = (ph % 2 == 0) ? 17 : 0;
            out_gap_max = (ph % 4 == 0 || ph % 4 == 3) ? 17 : 0;
            for (int j = 0; j < ALARM_WORDS; j++) begin
                aw = $urandom;
                if ($urandom_range(0, 9) != 0) begin
                    aw.enable = ($urandom_range(0, 7) != 0);
                    aw.once = ($urandom_range(0, 3) == 0);
                    aw.hour = 8'($urandom_range(0, 23));
                    aw.minute = 8'($urandom_range(0, 59));
                    if ($urandom_range(0, 2) == 0) aw.day_mask = '0;
                end
                write_reg(t_reg_idx'(j), aw);
            end
            write_reg(REG_RING_LIMIT, lim);
            write_reg(REG_BLINK_PER, {16'($urandom), per[15:0]});
            write_reg(REG_SNOOZE_SEC, {16'($urandom), snz[15:0]});
            write_reg(REG_CLOCK_FLOOR, flr);
            setting_count++;
            clock_s = flr + $urandom_range(0, 600);
            clock_ms = $urandom;
            snooze_at_gen = clock_s;
            @(posedge clk);
            for (int n = 0; n < WORDS_PER_SET; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) clock_s += $urandom_range(0, 130);
                else if (pick < 75) clock_s = snooze_at_gen - 3 + $urandom_range(0, 100);
                else if (pick < 88) clock_s += $urandom_range(60, 5000);
                else if (pick < 95) clock_s = $urandom;
                else clock_s = 32'hFFFF_FFFF;
                pick = $urandom_range(0, 99);
                if (pick < 50) clock_ms += $urandom_range(0, 2 * blink_period + 2);
                else if (pick < 75)
                    clock_ms += $urandom_range(0, (ring_limit > 32'h4000_0000) ?
                                                  32'hFFFF_FFFF : 2 * ring_limit + 2);
                else if (pick < 90) clock_ms += $urandom_range(0, 20);
                else clock_ms = $urandom;
                aw = alarm_reg[$urandom_range(0, ALARM_WORDS - 1)];
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    h = aw.hour[4:0];
                    mi = aw.minute[5:0];
                end else if (pick < 95) begin
                    h = 5'($urandom_range(0, 23));
                    mi = 6'($urandom_range(0, 59));
                end else begin
                    h = 5'($urandom);
                    mi = 6'($urandom);
                end
                pick = $urandom_range(0, 99);
                if (pick < 64) begin
                    k = KIND_TICK;
                end else if (pick < 77) begin
                    k = KIND_SNOOZE;
                    snooze_at_gen = clock_s + 32'(snooze_sec);
                end else if (pick < 87) begin
                    k = KIND_DISMISS;
                end else begin
                    k = KIND_TEST;
                end
                add_word(k, clock_s, clock_ms, h, mi, 3'($urandom_range(0, 7)));
            end
            drain();
        end

        $display("Checked %0d result words for %0d input words over %0d register settings.",
                 results_checked, words_sent, setting_count);
        $display("Seen %0d alarm rings, %0d snooze rings, %0d auto dismissals, %0d snoozes, %0d dismissals, %0d test fires.",
                 event_count[EV_ALARM], event_count[EV_SNZ_RING], event_count[EV_AUTO_DISM],
                 event_count[EV_SNOOZED], event_count[EV_DISMISSED], event_count[EV_TEST]);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
